/* rtl/mf3_pkg.sv */
`timescale 1ns / 1ps

package mf3_pkg;

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int ROWS_REG_W = 13;
  localparam int COLS_REG_W = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Column positions travel at the width of the largest supported line.
  localparam int COL_MAX_W  = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  // Register reset values and limits.
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 13'd480;
  localparam int COLS_RESET    = 640;
  localparam int MAX_ROWS      = 4096;
  localparam int DEF_MAX_WIDTH = 1024;

  // Queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Divide by nine as a multiply by a scaled reciprocal. With the shift three
  // bits above the sum width the error term stays below one for every sum.
  localparam int SUM_W       = PIX_W + 4;
  localparam int DIV9_SHIFT  = SUM_W + 3;
  localparam int DIV9_MULT_W = SUM_W;
  localparam logic [DIV9_MULT_W-1:0] DIV9_MULT =
    DIV9_MULT_W'(((1 << DIV9_SHIFT) + 8) / 9);
  localparam int PROD_W      = SUM_W + DIV9_MULT_W;

  // One classified pixel on its way from the front to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [PIX_W-1:0]     above1;
    logic [PIX_W-1:0]     above2;
    logic [ROW_W-1:0]     row;
    logic [COL_MAX_W-1:0] col;
    logic                 interior;
    logic                 border;
  } mf3_item_t;

endpackage

/* rtl/mf3_pix_if.sv */
`timescale 1ns / 1ps

interface mf3_pix_if
  import mf3_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/mf3_res_if.sv */
`timescale 1ns / 1ps

interface mf3_res_if
  import mf3_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic [PIX_W-1:0]     value;
  logic                 last_of_run;

  modport source (output valid, output out_row, output out_col, output value,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input value,
                  input last_of_run, output ready);
endinterface

/* rtl/mf3_front.sv */
`timescale 1ns / 1ps

module mf3_front
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mf3_pix_if.sink               pix_in,
  output logic                  item_valid,
  input  logic                  item_ready,
  output mf3_item_t             item
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int COLS_RST = (COLS_RESET > MAX_WIDTH) ? MAX_WIDTH : COLS_RESET;

  logic [ROWS_REG_W-1:0] rows_eff;
  logic [CW1-1:0]        cols_eff;
  logic [ROW_W-1:0]      row;
  logic [CW-1:0]         col;

  logic                  s1_valid;
  logic [PIX_W-1:0]      s1_pixel;
  logic [ROW_W-1:0]      s1_row;
  logic [CW-1:0]         s1_col;
  logic                  s1_interior;
  logic                  s1_border;

  // Each entry holds the two previous rows at one column: older above newer.
  logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]    line_rd;

  logic                  accept;
  logic                  move;
  logic                  cfg_hit;
  logic [ROWS_REG_W-1:0] row_inc;
  logic [CW1-1:0]        col_inc;
  logic                  last_col;
  logic                  last_row;
  logic                  is_border;
  logic                  is_interior;
  logic [ROWS_REG_W-1:0] rows_wr;
  logic [ROWS_REG_W-1:0] cols_wide;
  logic [ROWS_REG_W-1:0] cols_wr;

  assign move          = s1_valid && item_ready;
  assign pix_in.ready  = !s1_valid || item_ready;
  assign accept        = pix_in.valid && pix_in.ready;
  assign cfg_hit       = cfg_we && (cfg_index == REG_FRAME_ROWS ||
                                    cfg_index == REG_FRAME_COLS);

  // Position tests for the arriving pixel.
  assign row_inc     = {1'b0, row} + ROWS_REG_W'(1);
  assign col_inc     = CW1'(col) + CW1'(1);
  assign last_col    = col_inc >= cols_eff;
  assign last_row    = row_inc >= rows_eff;
  assign is_border   = (row == '0) || (row_inc == rows_eff) ||
                       (col == '0) || (col_inc == cols_eff);
  assign is_interior = (row >= ROW_W'(2)) && (CW1'(col) >= CW1'(2));

  // Register writes are clamped once, when they are taken.
  always_comb begin
    rows_wr = cfg_data[ROWS_REG_W-1:0];
    if (rows_wr == '0) begin
      rows_wr = ROWS_REG_W'(1);
    end else if (rows_wr > ROWS_REG_W'(MAX_ROWS)) begin
      rows_wr = ROWS_REG_W'(MAX_ROWS);
    end
    cols_wide = ROWS_REG_W'(cfg_data[COLS_REG_W-1:0]);
    cols_wr   = cols_wide;
    if (cols_wide == '0) begin
      cols_wr = ROWS_REG_W'(1);
    end else if (cols_wide > ROWS_REG_W'(MAX_WIDTH)) begin
      cols_wr = ROWS_REG_W'(MAX_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff <= ROWS_RESET;
      cols_eff <= CW1'(COLS_RST);
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_ROWS) begin
        rows_eff <= rows_wr;
      end else if (cfg_index == REG_FRAME_COLS) begin
        cols_eff <= CW1'(cols_wr);
      end
    end
  end

  // Raster position; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // Capture stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pix_in.pixel;
      s1_row      <= row;
      s1_col      <= col;
      s1_interior <= is_interior;
      s1_border   <= is_border;
    end
  end

  // Line memory: read on accept, write back the shifted pair when the
  // transaction leaves the capture stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col];
    end
    if (move) begin
      line_mem[s1_col] <= {line_rd[PIX_W-1:0], s1_pixel};
    end
  end

  assign item_valid    = s1_valid;
  assign item.pixel    = s1_pixel;
  assign item.above1   = line_rd[PIX_W-1:0];
  assign item.above2   = line_rd[2*PIX_W-1:PIX_W];
  assign item.row      = s1_row;
  assign item.col      = COL_MAX_W'(s1_col);
  assign item.interior = s1_interior;
  assign item.border   = s1_border;

endmodule

/* rtl/mf3_fifo.sv */
`timescale 1ns / 1ps

module mf3_fifo
  import mf3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mf3_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output mf3_item_t out_item
);

  mf3_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

/* rtl/mf3_back.sv */
`timescale 1ns / 1ps

module mf3_back
  import mf3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  mf3_item_t item,
  mf3_res_if.source res_out
);

  logic [PIX_W-1:0]  win [3][3];

  logic              w1_valid;
  mf3_item_t         w1_item;
  logic              s2_valid;
  mf3_item_t         s2_item;
  logic [SUM_W-1:0]  s2_sum;
  logic              s3_valid;
  mf3_item_t         s3_item;
  logic              s3_int;
  logic [PROD_W-1:0] s3_prod;

  logic              pop;
  logic              w1_has_res;
  logic              w1_move;
  logic              s2_load;
  logic              s2_move;
  logic              s3_move;
  logic              out_free;
  logic              emit;
  logic [SUM_W-1:0]  win_sum;
  logic [ROW_W-1:0]  int_row;
  logic [COL_MAX_W-1:0] int_col;

  // Stage handshakes, from the output backwards.
  assign out_free   = !res_out.valid || res_out.ready;
  assign emit       = s3_valid && out_free;
  assign s3_move    = emit && !(s3_int && s3_item.border);
  assign s2_move    = s2_valid && (!s3_valid || s3_move);
  assign w1_has_res = w1_item.interior || w1_item.border;
  assign w1_move    = w1_valid && (!w1_has_res || !s2_valid || s2_move);
  assign s2_load    = w1_move && w1_has_res;
  assign pop        = item_valid && (!w1_valid || w1_move);
  assign item_ready = !w1_valid || w1_move;

  // Sum of the nine window pixels.
  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_sum = win_sum + SUM_W'(win[i][j]);
      end
    end
  end

  // The window slides one column for every transaction taken from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (pop) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= item.above2;
      win[1][2] <= item.above1;
      win[2][2] <= item.pixel;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      w1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (pop) begin
        w1_valid <= 1'b1;
      end else if (w1_move) begin
        w1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (s3_move) begin
        s3_valid <= 1'b0;
      end
    end
  end

  // Stage payloads: window, sum, then scaled product.
  always_ff @(posedge clk) begin
    if (pop) begin
      w1_item <= item;
    end
    if (s2_load) begin
      s2_item <= w1_item;
      s2_sum  <= win_sum;
    end
    if (s2_move) begin
      s3_item <= s2_item;
      s3_prod <= PROD_W'(s2_sum) * PROD_W'(DIV9_MULT);
    end
  end

  // The interior flag is cleared once the filtered result has gone out, so
  // a transaction with two results emits the border result next.
  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_int <= s2_item.interior;
    end else if (emit && s3_int) begin
      s3_int <= 1'b0;
    end
  end

  assign int_row = s3_item.row - ROW_W'(1);
  assign int_col = s3_item.col - COL_MAX_W'(1);

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (emit) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (s3_int) begin
        res_out.out_row     <= int_row;
        res_out.out_col     <= OUT_COL_W'(int_col);
        res_out.value       <= s3_prod[DIV9_SHIFT +: PIX_W];
        res_out.last_of_run <= !s3_item.border;
      end else begin
        res_out.out_row     <= s3_item.row;
        res_out.out_col     <= OUT_COL_W'(s3_item.col);
        res_out.value       <= s3_item.pixel;
        res_out.last_of_run <= 1'b1;
      end
    end
  end

endmodule

/* rtl/mean_filter_3x3_top.sv */
`timescale 1ns / 1ps

// 3x3 mean filter over a raster-order grayscale pixel stream. The block
// counts row and column itself; border pixels are passed through as they
// arrive, and each interior pixel is replaced by the floor of its 3x3 sum
// divided by nine, delivered when the pixel below and to the right of it
// arrives. A transaction on pix_in yields zero, one or two transactions on
// res_out (filtered result first), with last_of_run set on the last one.
// One pixel is accepted per clock while the queue has room, and one result
// leaves per clock while res_out is ready. A pixel that yields two results
// holds the last pipeline stage until both have gone out. The four-entry
// queue between the pixel front end and the filter pipeline, together with
// the pipeline registers, soaks up short runs of such pixels, like the last
// column of each row. Along the last row of a frame every pixel from column
// 2 on yields two results, so there the input is held back once the queue
// has filled. Writing frame_rows (index 0) or frame_cols (index 1) restarts
// the frame at row 0, column 0; values are clamped to 1..4096 rows and
// 1..MAX_WIDTH columns. The line memory needs no initialization after reset.

module mean_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mf3_pix_if.sink               pix_in,
  mf3_res_if.source             res_out
);

  logic      fr_valid;
  logic      fr_ready;
  mf3_item_t fr_item;
  logic      bk_valid;
  logic      bk_ready;
  mf3_item_t bk_item;

  // Pixel counting, classification and line memory.
  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (pix_in),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  // Decoupling queue.
  mf3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_item  (bk_item)
  );

  // Window, averaging pipeline and result output.
  mf3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (bk_valid),
    .item_ready (bk_ready),
    .item       (bk_item),
    .res_out    (res_out)
  );

endmodule
